FILE: design/pcmsc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pcmsc_pkg
// Types and constants for the PCM16 soft-clip mixer.
// ---------------------------------------------------------------------------
package pcmsc_pkg;

   localparam int unsigned QUOT_BITS = 14;
   localparam int unsigned LATENCY   = QUOT_BITS + 3;

   localparam logic [16:0] CLIP_THRESHOLD = 17'd29491;
   localparam logic [16:0] Q15_ONE        = 17'd32768;

   localparam logic [15:0] PCM_MAX = 16'h7FFF;
   localparam logic [15:0] PCM_MIN = 16'h8000;

   localparam logic CSR_MIX_ENABLE = 1'b0;

   typedef struct packed {
      logic signed [15:0] injected_sample;
      logic signed [15:0] mic_sample;
      logic               last_in_buffer;
   } req_type;

   typedef struct packed {
      logic signed [15:0] mixed_sample;
      logic               last_out;
   } rsp_type;

endpackage
`default_nettype wire

FILE: design/pcm16_soft_clip_mixer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pcm16_soft_clip_mixer
// Adds two PCM16 samples, soft-compresses the excess above 0.9 full scale,
// scales by 32767/32768 and saturates; copy mode passes the injected sample.
// ---------------------------------------------------------------------------
// One sample is taken in every clock cycle: busy stays low and start alone
// accepts a beat. Each result appears on rsp_data with rsp_strobe high for
// exactly one cycle, in order, and the receiver cannot hold it off. The
// pipeline depth is set by the compression quotient, a restoring divider with
// one quotient bit per pipeline stage (14 stages), plus an input stage, a
// recombine stage and the scale-and-saturate output stage. mix_enable is
// sampled when a beat is accepted and travels with it.
module pcm16_soft_clip_mixer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire pcmsc_pkg::req_type req_data,
   output      logic               rsp_strobe,
   output      pcmsc_pkg::rsp_type rsp_data,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output      logic [31:0]        prdata,
   output      logic               pready
);
   import pcmsc_pkg::*;

   localparam int unsigned QB = QUOT_BITS;

   // configuration
   logic mix_enable_ff;
   logic csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;
   assign prdata = (paddr[2] == CSR_MIX_ENABLE) ? {31'd0, mix_enable_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_enable_ff <= 1'b0;
      end else if (csr_wr && (paddr[2] == CSR_MIX_ENABLE)) begin
         mix_enable_ff <= pwdata[0];
      end
   end

   assign busy = 1'b0;

   // pipeline stage registers, index 0 is the entry stage
   logic        vld_ff  [QB+1];
   logic        mix_ff  [QB+1];
   logic        neg_ff  [QB+1];
   logic        over_ff [QB+1];
   logic [14:0] mag_ff  [QB+1];
   logic [15:0] inj_ff  [QB+1];
   logic        last_ff [QB+1];
   logic [16:0] den_ff  [QB+1];
   logic [16:0] rem_ff  [QB+1];
   logic [QB-1:0] quo_ff [QB+1];

   // entry stage
   logic [16:0] sum_in;
   logic        neg_in;
   logic [16:0] mag_in;
   logic        over_in;
   logic [16:0] exc_full;
   logic [15:0] exc_in;
   logic [16:0] rem_in;
   logic [16:0] den_in;

   always_comb begin
      sum_in   = {req_data.injected_sample[15], req_data.injected_sample}
               + {req_data.mic_sample[15], req_data.mic_sample};
      neg_in   = sum_in[16];
      mag_in   = neg_in ? (~sum_in + 17'd1) : sum_in;
      over_in  = mag_in > CLIP_THRESHOLD;
      exc_full = mag_in - CLIP_THRESHOLD;
      exc_in   = over_in ? exc_full[15:0] : 16'd0;
      rem_in   = {exc_in, 1'b0};
      den_in   = Q15_ONE + {exc_in, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= start & ~busy;
      end
      mix_ff[0]  <= mix_enable_ff;
      neg_ff[0]  <= neg_in;
      over_ff[0] <= over_in;
      mag_ff[0]  <= mag_in[14:0];
      inj_ff[0]  <= req_data.injected_sample;
      last_ff[0] <= req_data.last_in_buffer;
      den_ff[0]  <= den_in;
      rem_ff[0]  <= rem_in;
      quo_ff[0]  <= '0;
   end

   // divider: one quotient bit per stage
   genvar g;
   for (g = 0; g < QB; g++) begin : g_div
      logic [17:0] shifted;
      logic [17:0] diff;
      logic        take;
      logic [16:0] rem_nxt_in;

      assign shifted    = {rem_ff[g], 1'b0};
      assign take       = shifted >= {1'b0, den_ff[g]};
      assign diff       = shifted - {1'b0, den_ff[g]};
      assign rem_nxt_in = take ? diff[16:0] : shifted[16:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else begin
            vld_ff[g+1] <= vld_ff[g];
         end
         mix_ff[g+1]  <= mix_ff[g];
         neg_ff[g+1]  <= neg_ff[g];
         over_ff[g+1] <= over_ff[g];
         mag_ff[g+1]  <= mag_ff[g];
         inj_ff[g+1]  <= inj_ff[g];
         last_ff[g+1] <= last_ff[g];
         den_ff[g+1]  <= den_ff[g];
         rem_ff[g+1]  <= rem_nxt_in;
         quo_ff[g+1]  <= {quo_ff[g][QB-2:0], take};
      end
   end

   // recombine stage
   logic        rc_vld_ff;
   logic        rc_mix_ff;
   logic        rc_neg_ff;
   logic [15:0] rc_inj_ff;
   logic        rc_last_ff;
   logic [15:0] rc_mag_ff;
   logic [15:0] rc_mag_in;

   assign rc_mag_in = over_ff[QB] ? (CLIP_THRESHOLD[15:0] + {{(16-QB){1'b0}}, quo_ff[QB]})
                                  : {1'b0, mag_ff[QB]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_vld_ff <= 1'b0;
      end else begin
         rc_vld_ff <= vld_ff[QB];
      end
      rc_mix_ff  <= mix_ff[QB];
      rc_neg_ff  <= neg_ff[QB];
      rc_inj_ff  <= inj_ff[QB];
      rc_last_ff <= last_ff[QB];
      rc_mag_ff  <= rc_mag_in;
   end

   // scale by 32767/32768, restore sign, saturate
   logic [30:0] prod;
   logic [15:0] scaled;
   logic [15:0] sample_in;
   logic [15:0] mixed_in;

   always_comb begin
      prod   = {rc_mag_ff, 15'd0} - {15'd0, rc_mag_ff};
      scaled = prod[30:15];
      if (rc_neg_ff) begin
         mixed_in = scaled[15] ? PCM_MIN : (~scaled + 16'd1);
      end else begin
         mixed_in = scaled[15] ? PCM_MAX : scaled;
      end
      sample_in = rc_mix_ff ? mixed_in : rc_inj_ff;
   end

   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rc_vld_ff;
      end
      rsp_data_ff.mixed_sample <= sample_in;
      rsp_data_ff.last_out     <= rc_last_ff;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTH
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && !reset, LATENCY))
      else $error("result strobe does not follow an accepted beat");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      $past(start && !busy && !reset, LATENCY) |-> rsp_strobe)
      else $error("accepted beat produced no result");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.last_out == $past(req_data.last_in_buffer, LATENCY))
      else $error("last marker lost in pipeline");

   a_copy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !$past(mix_enable_ff, LATENCY))
      |-> rsp_data.mixed_sample == $past(req_data.injected_sample, LATENCY))
      else $error("copy mode altered the injected sample");

   a_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[QB] |-> rem_ff[QB] < den_ff[QB])
      else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire
